// File: rtl/dad_pkg.sv
// Package for the date shifter: field widths, state encoding, month table
// and the leap-year helper. No dependencies.
package dad_pkg;

    localparam int YEAR_BITS   = 14;
    localparam int OFFSET_BITS = 17;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;

    // Working year must hold any year reached from any start and offset.
    localparam int YW = ((YEAR_BITS > OFFSET_BITS - 8) ? YEAR_BITS : OFFSET_BITS - 8) + 2;
    // Working day: start day plus offset, signed.
    localparam int DW = OFFSET_BITS + 1;

    // Year mod 400 is found by restoring subtraction of 400 << k.
    localparam int REM_W     = 9;
    localparam int RED_STEPS = YEAR_BITS - 8;
    localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
    localparam logic [REM_W-1:0]     REM_LAST = REM_W'(399);

    localparam logic [MONTH_W-1:0] M_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] M_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] M_DEC = MONTH_W'(12);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_WALK
    } t_state;

    // Month lengths, common year; codes outside 1..12 give 0.
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    // Leap from year mod 400: divisible by 4, and not 100/200/300 mod 400.
    function automatic logic is_leap(input logic [REM_W-1:0] rem);
        return (rem[1:0] == 2'b00) && (rem != REM_W'(100)) &&
               (rem != REM_W'(200)) && (rem != REM_W'(300));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic [REM_W-1:0] rem);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[m];
        if (m == M_FEB && is_leap(rem)) begin
            len = len + DAY_W'(1);
        end
        return len;
    endfunction

endpackage

// File: rtl/dad_if.sv
// Valid/ready channels of the date shifter, input and result side.
// Depends on dad_pkg for field widths.
interface dad_in_if;
    logic                                    valid;
    logic                                    ready;
    logic        [dad_pkg::YEAR_BITS-1:0]    start_year;
    logic        [dad_pkg::MONTH_W-1:0]      start_month;
    logic        [dad_pkg::DAY_W-1:0]        start_day;
    logic signed [dad_pkg::OFFSET_BITS-1:0]  day_offset;

    modport source (output valid, output start_year, output start_month,
                    output start_day, output day_offset, input ready);
    modport sink   (input valid, input start_year, input start_month,
                    input start_day, input day_offset, output ready);
endinterface

interface dad_out_if;
    logic                             valid;
    logic                             ready;
    logic [dad_pkg::YEAR_BITS-1:0]    result_year;
    logic [dad_pkg::MONTH_W-1:0]      result_month;
    logic [dad_pkg::DAY_W-1:0]        result_day;
    logic                             input_invalid;
    logic                             year_out_of_range;

    modport source (output valid, output result_year, output result_month,
                    output result_day, output input_invalid,
                    output year_out_of_range, input ready);
    modport sink   (input valid, input result_year, input result_month,
                    input result_day, input input_invalid,
                    input year_out_of_range, output ready);
endinterface

// File: rtl/date_add_days.sv
// Date shifter top level: Gregorian date plus signed day offset.
// Depends on dad_pkg and the channel interfaces in dad_if.sv.
//
// Takes one beat (year, month, day, signed offset) and returns one beat with
// the shifted date. The walk moves one month per cycle through a single
// shared day adder: forward it subtracts the current month's length while the
// day exceeds it, backward it steps to the previous month and adds that
// month's length while the day is below 1. Leap years come from a year-mod-400
// register that is first computed by restoring subtraction and then tracked
// as the year steps. An item passes through the idle state that takes the
// beat, the reduction, the check, the month walk and a last walk step that
// loads the result once the output register is free. Ready is high only while
// idle, but a finished result waits in its own output register, so the next
// beat is taken while the previous result is still unread. An invalid start
// date (month outside 1..12, day 0 or past month end) returns all zeros with
// input_invalid set, loaded from the check. year_out_of_range flags a year
// below 0 or above 2^YEAR_BITS-1; result_year then holds the wrapped low bits.
module date_add_days (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dad_in_if.sink         i_in,
    dad_out_if.source      o_out
);

    dad_pkg::t_state                      r_state, n_state;
    logic signed [dad_pkg::YW-1:0]        r_year, n_year;
    logic [dad_pkg::MONTH_W-1:0]          r_month, n_month;
    logic signed [dad_pkg::DW-1:0]        r_day, n_day;
    logic signed [dad_pkg::DW-1:0]        r_off, n_off;
    logic [dad_pkg::YEAR_BITS-1:0]        r_rem, n_rem;     // year mod 400 when walking
    logic [dad_pkg::STEP_W-1:0]           r_step, n_step;

    logic                                 r_ovalid, n_ovalid;
    logic [dad_pkg::YEAR_BITS-1:0]        r_oyear, n_oyear;
    logic [dad_pkg::MONTH_W-1:0]          r_omonth, n_omonth;
    logic [dad_pkg::DAY_W-1:0]            r_oday, n_oday;
    logic                                 r_oinv, n_oinv;
    logic                                 r_ooor, n_ooor;

    // Walk datapath
    logic [dad_pkg::REM_W-1:0]            rem9, prev_rem, next_rem;
    logic [dad_pkg::MONTH_W-1:0]          prev_month, next_month;
    logic [dad_pkg::DAY_W-1:0]            len_cur, len_prev;
    logic signed [dad_pkg::DW-1:0]        len_cur_s, len_prev_s, add_op, add_sum;
    logic                                 fwd, bwd, slot_free, year_oor;
    logic [dad_pkg::YEAR_BITS-1:0]        red_cmp;

    assign rem9       = r_rem[dad_pkg::REM_W-1:0];
    assign prev_month = (r_month == dad_pkg::M_JAN) ? dad_pkg::M_DEC
                                                     : r_month - dad_pkg::MONTH_W'(1);
    assign next_month = (r_month == dad_pkg::M_DEC) ? dad_pkg::M_JAN
                                                     : r_month + dad_pkg::MONTH_W'(1);
    // mod-400 of the neighbor year, only used across a year boundary
    assign prev_rem   = (r_month != dad_pkg::M_JAN) ? rem9 :
                        (rem9 == '0) ? dad_pkg::REM_LAST : rem9 - dad_pkg::REM_W'(1);
    assign next_rem   = (rem9 == dad_pkg::REM_LAST) ? '0 : rem9 + dad_pkg::REM_W'(1);

    assign len_cur    = dad_pkg::month_len(r_month, rem9);
    assign len_prev   = dad_pkg::month_len(prev_month, prev_rem);
    assign len_cur_s  = signed'(dad_pkg::DW'(len_cur));
    assign len_prev_s = signed'(dad_pkg::DW'(len_prev));

    assign fwd = r_day > len_cur_s;
    assign bwd = r_day < signed'(dad_pkg::DW'(1));

    // The one shared adder: start-day plus offset, or day -/+ month length.
    always_comb begin
        add_op = r_off;
        if (r_state == dad_pkg::S_WALK) begin
            add_op = fwd ? -len_cur_s : len_prev_s;
        end
    end
    assign add_sum = r_day + add_op;

    assign red_cmp   = dad_pkg::YEAR_BITS'(400) << r_step;
    assign slot_free = !r_ovalid || o_out.ready;
    assign year_oor  = (r_year < 0) ||
        (r_year > signed'({{(dad_pkg::YW-dad_pkg::YEAR_BITS){1'b0}}, dad_pkg::YEAR_MAX}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dad_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year   <= n_year;
        r_month  <= n_month;
        r_day    <= n_day;
        r_off    <= n_off;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_oyear  <= n_oyear;
        r_omonth <= n_omonth;
        r_oday   <= n_oday;
        r_oinv   <= n_oinv;
        r_ooor   <= n_ooor;
    end

    always_comb begin
        n_state  = r_state;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_off    = r_off;
        n_rem    = r_rem;
        n_step   = r_step;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oyear  = r_oyear;
        n_omonth = r_omonth;
        n_oday   = r_oday;
        n_oinv   = r_oinv;
        n_ooor   = r_ooor;

        case (r_state)
            dad_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_year  = signed'(dad_pkg::YW'(i_in.start_year));
                    n_month = i_in.start_month;
                    n_day   = signed'(dad_pkg::DW'(i_in.start_day));
                    n_off   = dad_pkg::DW'(i_in.day_offset);
                    n_rem   = i_in.start_year;
                    n_step  = dad_pkg::STEP_W'(dad_pkg::RED_STEPS - 1);
                    n_state = dad_pkg::S_REDUCE;
                end
            end
            dad_pkg::S_REDUCE: begin
                if (r_rem >= red_cmp) begin
                    n_rem = r_rem - red_cmp;
                end
                if (r_step == '0) begin
                    n_state = dad_pkg::S_CHECK;
                end else begin
                    n_step = r_step - dad_pkg::STEP_W'(1);
                end
            end
            dad_pkg::S_CHECK: begin
                // month code outside 1..12 has length 0, so one test covers both
                if (r_day == '0 || r_day > len_cur_s) begin
                    if (slot_free) begin
                        n_ovalid = 1'b1;
                        n_oyear  = '0;
                        n_omonth = '0;
                        n_oday   = '0;
                        n_oinv   = 1'b1;
                        n_ooor   = 1'b0;
                        n_state  = dad_pkg::S_IDLE;
                    end
                end else begin
                    n_day   = add_sum;
                    n_state = dad_pkg::S_WALK;
                end
            end
            dad_pkg::S_WALK: begin
                if (fwd) begin
                    n_day   = add_sum;
                    n_month = next_month;
                    if (r_month == dad_pkg::M_DEC) begin
                        n_year = r_year + dad_pkg::YW'(1);
                        n_rem  = dad_pkg::YEAR_BITS'(next_rem);
                    end
                end else if (bwd) begin
                    n_day   = add_sum;
                    n_month = prev_month;
                    n_rem   = dad_pkg::YEAR_BITS'(prev_rem);
                    if (r_month == dad_pkg::M_JAN) begin
                        n_year = r_year - dad_pkg::YW'(1);
                    end
                end else if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_oyear  = r_year[dad_pkg::YEAR_BITS-1:0];
                    n_omonth = r_month;
                    n_oday   = r_day[dad_pkg::DAY_W-1:0];
                    n_oinv   = 1'b0;
                    n_ooor   = year_oor;
                    n_state  = dad_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dad_pkg::S_IDLE;
            end
        endcase
    end

    assign i_in.ready              = (r_state == dad_pkg::S_IDLE);
    assign o_out.valid             = r_ovalid;
    assign o_out.result_year       = r_oyear;
    assign o_out.result_month      = r_omonth;
    assign o_out.result_day        = r_oday;
    assign o_out.input_invalid     = r_oinv;
    assign o_out.year_out_of_range = r_ooor;

    // Year mod 400 stays reduced during the walk
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dad_pkg::S_WALK |-> r_rem < dad_pkg::YEAR_BITS'(400))
        else $error("year remainder not reduced during walk");

    // The walk never leaves the 1..12 month range
    a_walk_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dad_pkg::S_WALK |->
            (r_month >= dad_pkg::M_JAN && r_month <= dad_pkg::M_DEC))
        else $error("month out of range during walk");

    // A valid result is a real calendar date
    a_result_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.input_invalid |->
            (o_out.result_month >= dad_pkg::M_JAN && o_out.result_month <= dad_pkg::M_DEC &&
             o_out.result_day != '0))
        else $error("result is not a calendar date");

    // An invalid start date gives an all-zero result
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.input_invalid |->
            (o_out.result_year == '0 && o_out.result_month == '0 &&
             o_out.result_day == '0 && !o_out.year_out_of_range))
        else $error("invalid start date with nonzero result");

    // New results come only from the check or the end of the walk
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |->
            ($past(r_state) == dad_pkg::S_CHECK || $past(r_state) == dad_pkg::S_WALK))
        else $error("result loaded outside check or walk");

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the date shifter: directed table plus random date beats.
// Depends on dad_pkg, dad_if.sv (dad_in_if, dad_out_if) and date_add_days.
`timescale 1ns / 100ps

module tb_top;

    // Quiet-cycle limit. The slowest beat (full 17-bit offset) walks about
    // 2150 months, plus the long result hold, plus a long sender gap.
    localparam int STALL_LIMIT  = 12000;
    localparam int RANDOM_BEATS = 680;
    // Random beat index at which the sender waits for the pipe to drain.
    localparam int DRAIN_AT     = 450;
    // Result count at which the sink holds off ready for a long stretch.
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;
    // Tail wait after the last result.
    localparam int TAIL_CYCLES  = 40;

    typedef logic        [dad_pkg::YEAR_BITS-1:0]   t_year;
    typedef logic        [dad_pkg::MONTH_W-1:0]     t_month;
    typedef logic        [dad_pkg::DAY_W-1:0]       t_day;
    typedef logic signed [dad_pkg::OFFSET_BITS-1:0] t_offset;

    typedef struct packed {
        t_year   year;
        t_month  month;
        t_day    day;
        t_offset offset;
    } t_date_req;

    typedef struct packed {
        t_year  year;
        t_month month;
        t_day   day;
        logic   input_invalid;
        logic   year_out_of_range;
    } t_date_res;

    // Directed row: start date, offset, and (typed = 1) an expected result
    // that can be read off directly; other rows go through the predictor.
    typedef struct {
        int year, month, day, offset;
        int typed;
        int e_year, e_month, e_day, e_invalid, e_oor;
    } t_dir_row;

    localparam int DIR_ROWS = 26;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // leap days with zero offset: 4-year and 400-year rules
        '{2024, 2, 29, 0, 1, 2024, 2, 29, 0, 0},
        '{2000, 2, 29, 0, 1, 2000, 2, 29, 0, 0},
        // Feb 29 in a common year and in a century common year
        '{2023, 2, 29, 0, 1, 0, 0, 0, 1, 0},
        '{1900, 2, 29, 0, 1, 0, 0, 0, 1, 0},
        // bad month codes, bad day codes
        '{2023, 0, 1, 5, 1, 0, 0, 0, 1, 0},
        '{2023, 13, 1, 5, 1, 0, 0, 0, 1, 0},
        '{2023, 15, 31, -1, 1, 0, 0, 0, 1, 0},
        '{2023, 4, 31, 0, 1, 0, 0, 0, 1, 0},
        '{2023, 1, 0, 0, 1, 0, 0, 0, 1, 0},
        // field extremes, zero offset
        '{2023, 1, 31, 0, 1, 2023, 1, 31, 0, 0},
        '{0, 1, 1, 0, 1, 0, 1, 1, 0, 0},
        '{16383, 12, 31, 0, 1, 16383, 12, 31, 0, 0},
        // year wraps past either end
        '{16383, 12, 31, 1, 1, 0, 1, 1, 0, 1},
        '{0, 1, 1, -1, 1, 16383, 12, 31, 0, 1},
        // month and year boundaries, February both ways
        '{2023, 12, 31, 1, 0, 0, 0, 0, 0, 0},
        '{2024, 1, 1, -1, 0, 0, 0, 0, 0, 0},
        '{2024, 2, 28, 1, 0, 0, 0, 0, 0, 0},
        '{2100, 2, 28, 1, 0, 0, 0, 0, 0, 0},
        '{2023, 3, 1, -1, 0, 0, 0, 0, 0, 0},
        '{2000, 3, 1, -1, 0, 0, 0, 0, 0, 0},
        '{1999, 12, 31, 366, 0, 0, 0, 0, 0, 0},
        // offset extremes, including the most negative code
        '{2000, 3, 1, 65535, 0, 0, 0, 0, 0, 0},
        '{8000, 6, 15, -65536, 0, 0, 0, 0, 0, 0},
        '{5000, 7, 31, -65535, 0, 0, 0, 0, 0, 0},
        '{16383, 1, 1, 65535, 0, 0, 0, 0, 0, 0},
        '{0, 12, 31, -65535, 0, 0, 0, 0, 0, 0}
    };

    logic clk = 1'b0;
    logic rst_n;

    dad_in_if  date_in ();
    dad_out_if date_out ();

    date_add_days u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (date_in),
        .o_out   (date_out)
    );

    always #1 clk = ~clk;

    // Shifted dates still owed by the block, oldest first.
    t_date_res expected_dates [$];

    int errors          = 0;
    int beats_sent      = 0;
    int invalid_starts  = 0;
    int year_overflows  = 0;
    int results_checked = 0;
    int idle_pct        = 0;   // shared idling rate, set per phase by the sender
    int quiet_cycles    = 0;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Gregorian month length; 0 for a month code outside 1..12.
    function automatic int days_in_month(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2: begin
                if (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) begin
                    return 29;
                end
                return 28;
            end
            default:               return 0;
        endcase
    endfunction

    // Walks the date month by month; year is kept wide so wraps are seen.
    function automatic t_date_res shift_date(t_date_req r);
        t_date_res res;
        int y;
        int m;
        int d;
        y   = int'(r.year);
        m   = int'(r.month);
        d   = int'(r.day);
        res = '0;
        if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
            res.input_invalid = 1'b1;
            return res;
        end
        d = d + int'(r.offset);
        while (d > days_in_month(y, m)) begin
            d = d - days_in_month(y, m);
            m = m + 1;
            if (m > 12) begin
                m = 1;
                y = y + 1;
            end
        end
        while (d < 1) begin
            m = m - 1;
            if (m < 1) begin
                m = 12;
                y = y - 1;
            end
            d = d + days_in_month(y, m);
        end
        res.year              = t_year'(y);
        res.month             = t_month'(m);
        res.day               = t_day'(d);
        res.year_out_of_range = (y < 0) || (y > int'(dad_pkg::YEAR_MAX));
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len(int pct);
        if (int'($urandom_range(0, 99)) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return int'($urandom_range(10, 60));
        end
        return int'($urandom_range(1, 3));
    endfunction

    // Mostly well-formed dates with small offsets so the month walk stays
    // short; a few full-range offsets, plus raw-bit and near-miss noise.
    function automatic t_date_req random_date_beat();
        t_date_req r;
        int y;
        int m;
        int d;
        int off;
        int sel;
        sel = int'($urandom_range(0, 99));
        if (sel < 8) begin
            // raw bits in every field; a small offset, most of the time, keeps stray valid dates quick
            r.year  = t_year'($urandom);
            r.month = t_month'($urandom);
            r.day   = t_day'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                r.offset = t_offset'($urandom);
            end else begin
                r.offset = t_offset'(int'($urandom_range(0, 800)) - 400);
            end
            return r;
        end
        case ($urandom_range(0, 9))
            0:       y = int'($urandom_range(0, 5));
            1:       y = int'($urandom_range(16378, 16383));
            2:       y = 100 * int'($urandom_range(0, 163));
            default: y = int'($urandom_range(0, 16383));
        endcase
        m = int'($urandom_range(1, 12));
        if (sel < 14) begin
            // one past month end, or day zero
            d = ($urandom_range(0, 1) == 0) ? days_in_month(y, m) + 1 : 0;
        end else begin
            d = int'($urandom_range(1, days_in_month(y, m)));
        end
        sel = int'($urandom_range(0, 99));
        if (sel < 5) begin
            off = int'($urandom_range(0, 131071)) - 65536;
        end else if (sel < 20) begin
            off = int'($urandom_range(0, 10000)) - 5000;
        end else begin
            off = int'($urandom_range(0, 800)) - 400;
        end
        r.year   = t_year'(y);
        r.month  = t_month'(m);
        r.day    = t_day'(d);
        r.offset = t_offset'(off);
        return r;
    endfunction

    // Holds one beat on the input channel until it is taken, then records
    // what the block owes for it.
    task automatic offer(input t_date_req r, input t_date_res want);
        date_in.valid       <= 1'b1;
        date_in.start_year  <= r.year;
        date_in.start_month <= r.month;
        date_in.start_day   <= r.day;
        date_in.day_offset  <= r.offset;
        do @(posedge clk); while (!date_in.ready);
        expected_dates.push_back(want);
        beats_sent++;
        if (want.input_invalid) begin
            invalid_starts++;
        end
        if (want.year_out_of_range) begin
            year_overflows++;
        end
    endtask

    // Sender gap after a taken beat; valid drops only if the gap is non-zero.
    task automatic sender_gap();
        int gap;
        gap = idle_len(idle_pct);
        if (gap > 0) begin
            date_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        t_date_res want;
        results_checked++;
        if (expected_dates.size() == 0) begin
            $display("%0t: result %0d-%0d-%0d arrived with nothing expected", $time,
                     date_out.result_year, date_out.result_month, date_out.result_day);
            errors++;
            return;
        end
        want = expected_dates.pop_front();
        check_field("result_year", int'(want.year), int'(date_out.result_year));
        check_field("result_month", int'(want.month), int'(date_out.result_month));
        check_field("result_day", int'(want.day), int'(date_out.result_day));
        check_field("input_invalid", int'(want.input_invalid),
                    int'(date_out.input_invalid));
        check_field("year_out_of_range", int'(want.year_out_of_range),
                    int'(date_out.year_out_of_range));
    endtask

    // ---------------------------------------------------------------------
    // Result sink: random ready stalls, one long hold so the block backs up
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int  hold;
        bit  long_hold_done;
        hold           = 0;
        long_hold_done = 1'b0;
        date_out.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (date_out.valid && date_out.ready) begin
                check_result();
            end
            if (hold > 0) begin
                hold--;                          // ready stays low
            end else if (rst_n && !long_hold_done && results_checked >= HOLD_AT) begin
                // sender keeps offering; block finishes one, takes one, stalls
                long_hold_done = 1'b1;
                hold           = HOLD_CYCLES;
                date_out.ready <= 1'b0;
            end else begin
                hold           = idle_len(idle_pct);
                date_out.ready <= (hold == 0) && rst_n;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: too many cycles with no beat on either channel
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        if ((date_in.valid && date_in.ready) || (date_out.valid && date_out.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_date_req req;
        t_date_res want;
        rst_n               <= 1'b0;
        date_in.valid       <= 1'b0;
        date_in.start_year  <= '0;
        date_in.start_month <= '0;
        date_in.start_day   <= '0;
        date_in.day_offset  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back.
        idle_pct = 0;
        for (int i = 0; i < DIR_ROWS; i++) begin
            req.year   = t_year'(dir_rows[i].year);
            req.month  = t_month'(dir_rows[i].month);
            req.day    = t_day'(dir_rows[i].day);
            req.offset = t_offset'(dir_rows[i].offset);
            if (dir_rows[i].typed != 0) begin
                want.year              = t_year'(dir_rows[i].e_year);
                want.month             = t_month'(dir_rows[i].e_month);
                want.day               = t_day'(dir_rows[i].e_day);
                want.input_invalid     = (dir_rows[i].e_invalid != 0);
                want.year_out_of_range = (dir_rows[i].e_oor != 0);
            end else begin
                want = shift_date(req);
            end
            offer(req, want);
        end

        // Random part; idling rate changes every 80 beats, one phase has none.
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            case ((i / 80) % 4)
                0:       idle_pct = 30;
                1:       idle_pct = 0;
                2:       idle_pct = 60;
                default: idle_pct = 15;
            endcase
            req = random_date_beat();
            offer(req, shift_date(req));
            if (i == DRAIN_AT) begin
                // pause until every owed result is back
                date_in.valid <= 1'b0;
                do @(posedge clk); while (expected_dates.size() != 0);
            end else begin
                sender_gap();
            end
        end

        date_in.valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Shifted %0d dates (%0d invalid starts, %0d year wraps), %0d results checked,",
                 beats_sent, invalid_starts, year_overflows, results_checked);
        $display("under random stalls on both sides, one long result hold and one drain.");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
